// ===== rtl/rar_pkg.sv =====
// rar_pkg: shared types and constants of the rational arithmetic block
// used by rar_divider and rational_arith_reduce; no dependencies
package rar_pkg;
   // working operand width: a 16-bit field, sign- or zero-extended
   localparam int OpW = 17;
   // product width and working value width of numerator and denominator
   localparam int ProdW = 2 * OpW;
   localparam int ValW = ProdW + 2;
   localparam int CntW = $clog2(ValW);

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   typedef logic [ValW-1:0] val_type;

   typedef struct packed {
      logic    start;
      val_type dividend;
      val_type divisor;
   } div_req_type;
endpackage

// ===== rtl/rar_divider.sv =====
// rar_divider: shared unsigned restoring divider, one quotient bit per cycle
// depends on rar_pkg
module rar_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rar_pkg::div_req_type div_req,
   output logic                 done,
   output rar_pkg::val_type     quotient,
   output rar_pkg::val_type     remainder
);
   import rar_pkg::*;

   logic [ValW:0]   rem_ff, rem_in;
   val_type         quo_ff, quo_in;
   val_type         dvs_ff, dvs_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [ValW:0]   rem_sh;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      rem_sh = {rem_ff[ValW-1:0], quo_ff[ValW-1]};
      if (div_req.start) begin
         rem_in = '0;
         quo_in = div_req.dividend;
         dvs_in = div_req.divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[ValW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[ValW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(ValW - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff[ValW-1:0];
endmodule

// ===== rtl/rational_arith_reduce.sv =====
// Fraction add, subtract, multiply or divide with reduction by the GCD of the
// magnitudes of the result. One request at a time: busy is high from the edge
// that takes start and is low again in the cycle of rsp_strobe. The GCD is
// found by Euclid remainder steps on the shared bit-serial divider, which then
// divides the numerator and the denominator by it. Zero numerator gives 0/1
// and zero denominator an error result, both without the divider. The result
// is shown for one cycle and cannot be held off by the receiver.
// depends on rar_pkg and rar_divider
module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_num_a,
   input  logic [15:0] req_den_a,
   input  logic [15:0] req_num_b,
   input  logic [15:0] req_den_b,
   input  logic        req_last_in,
   output logic        rsp_strobe,
   output logic [32:0] rsp_res_num,
   output logic [31:0] rsp_res_den,
   output logic        rsp_zero_den_error,
   output logic        rsp_last_out
);
   import rar_pkg::*;

   localparam int SW = (OPERAND_WIDTH < 16) ? OPERAND_WIDTH : 16;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_MUL       = 4'd1;
   localparam logic [3:0] S_COMB      = 4'd2;
   localparam logic [3:0] S_GCD       = 4'd3;
   localparam logic [3:0] S_GCD_WAIT  = 4'd4;
   localparam logic [3:0] S_DIVN      = 4'd5;
   localparam logic [3:0] S_DIVN_WAIT = 4'd6;
   localparam logic [3:0] S_DIVD      = 4'd7;
   localparam logic [3:0] S_DIVD_WAIT = 4'd8;

   logic [3:0]              state_ff, state_in;
   logic [1:0]              step_ff, step_in;
   logic [1:0]              mode_ff, mode_in;
   logic signed [OpW-1:0]   na_ff, na_in, da_ff, da_in, nb_ff, nb_in, db_ff, db_in;
   logic                    last_ff, last_in;
   logic signed [ProdW-1:0] p_ff, p_in, q_ff, q_in, d_ff, d_in;
   logic signed [ValW-1:0]  num_ff, num_in, den_ff, den_in;
   val_type                 a_ff, a_in, b_ff, b_in;
   logic                    strobe_ff, strobe_in;
   logic [32:0]             rnum_ff, rnum_in;
   logic [31:0]             rden_ff, rden_in;
   logic                    err_ff, err_in;
   logic                    lout_ff, lout_in;

   logic signed [OpW-1:0]   mul_x, mul_y;
   logic signed [ProdW-1:0] mul_p;
   logic signed [ValW-1:0]  comb_num, comb_den;
   val_type                 num_mag, den_mag;
   div_req_type             div_req;
   logic                    div_done;
   val_type                 div_quo, div_rem;

   function automatic logic signed [OpW-1:0] ext_op(input logic [15:0] f);
      if (OPERAND_WIDTH > 16) begin
         return {1'b0, f};
      end
      return OpW'($signed(f[SW-1:0]));
   endfunction

   rar_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // one shared multiplier, operand pair picked by step and operation
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_x = na_ff;
            mul_y = (mode_ff == MODE_MUL) ? nb_ff : db_ff;
         end
         2'd1: begin
            mul_x = nb_ff;
            mul_y = da_ff;
         end
         default: begin
            mul_x = da_ff;
            mul_y = db_ff;
         end
      endcase
      mul_p = mul_x * mul_y;
   end

   assign num_mag = num_ff[ValW-1] ? val_type'(-num_ff) : val_type'(num_ff);
   assign den_mag = den_ff[ValW-1] ? val_type'(-den_ff) : val_type'(den_ff);

   always_comb begin
      comb_num = ValW'(p_ff);
      comb_den = ValW'(d_ff);
      if (mode_ff == MODE_ADD || mode_ff == MODE_SUB) begin
         if (da_ff == db_ff) begin
            comb_den = ValW'(da_ff);
            comb_num = (mode_ff == MODE_SUB) ? ValW'(na_ff) - ValW'(nb_ff)
                                             : ValW'(na_ff) + ValW'(nb_ff);
         end else begin
            comb_num = (mode_ff == MODE_SUB) ? ValW'(p_ff) - ValW'(q_ff)
                                             : ValW'(p_ff) + ValW'(q_ff);
         end
      end else if (mode_ff == MODE_DIV) begin
         comb_den = ValW'(q_ff);
      end
   end

   always_comb begin
      div_req.start = 1'b0;
      div_req.dividend = den_mag;
      div_req.divisor = a_ff;
      case (state_ff)
         S_GCD: begin
            div_req.start = (b_ff != '0);
            div_req.dividend = a_ff;
            div_req.divisor = b_ff;
         end
         S_DIVN: begin
            div_req.start = 1'b1;
            div_req.dividend = num_mag;
         end
         S_DIVD: div_req.start = 1'b1;
         default: div_req.start = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      mode_in = mode_ff;
      na_in = na_ff;
      da_in = da_ff;
      nb_in = nb_ff;
      db_in = db_ff;
      last_in = last_ff;
      p_in = p_ff;
      q_in = q_ff;
      d_in = d_ff;
      num_in = num_ff;
      den_in = den_ff;
      a_in = a_ff;
      b_in = b_ff;
      strobe_in = 1'b0;
      rnum_in = rnum_ff;
      rden_in = rden_ff;
      err_in = err_ff;
      lout_in = lout_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               na_in = ext_op(req_num_a);
               da_in = ext_op(req_den_a);
               nb_in = ext_op(req_num_b);
               db_in = ext_op(req_den_b);
               last_in = req_last_in;
               step_in = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            case (step_ff)
               2'd0: p_in = mul_p;
               2'd1: q_in = mul_p;
               default: d_in = mul_p;
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               state_in = S_COMB;
            end
         end
         S_COMB: begin
            num_in = comb_num;
            den_in = comb_den;
            lout_in = last_ff;
            if (comb_den == '0) begin
               rnum_in = comb_num[32:0];
               rden_in = '0;
               err_in = 1'b1;
               strobe_in = 1'b1;
               state_in = S_IDLE;
            end else if (comb_num == '0) begin
               rnum_in = '0;
               rden_in = 32'd1;
               err_in = 1'b0;
               strobe_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               a_in = comb_num[ValW-1] ? val_type'(-comb_num) : val_type'(comb_num);
               b_in = comb_den[ValW-1] ? val_type'(-comb_den) : val_type'(comb_den);
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            // a holds the gcd once the remainder reaches zero
            state_in = (b_ff == '0) ? S_DIVN : S_GCD_WAIT;
         end
         S_GCD_WAIT: begin
            if (div_done) begin
               a_in = b_ff;
               b_in = div_rem;
               state_in = S_GCD;
            end
         end
         S_DIVN: state_in = S_DIVN_WAIT;
         S_DIVN_WAIT: begin
            if (div_done) begin
               num_in = num_ff[ValW-1] ? -$signed(div_quo) : $signed(div_quo);
               state_in = S_DIVD;
            end
         end
         S_DIVD: state_in = S_DIVD_WAIT;
         S_DIVD_WAIT: begin
            if (div_done) begin
               den_in = den_ff[ValW-1] ? -$signed(div_quo) : $signed(div_quo);
               rnum_in = num_ff[32:0];
               rden_in = den_in[31:0];
               err_in = 1'b0;
               strobe_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= strobe_in;
      end
      step_ff <= step_in;
      mode_ff <= mode_in;
      na_ff <= na_in;
      da_ff <= da_in;
      nb_ff <= nb_in;
      db_ff <= db_in;
      last_ff <= last_in;
      p_ff <= p_in;
      q_ff <= q_in;
      d_ff <= d_in;
      num_ff <= num_in;
      den_ff <= den_in;
      a_ff <= a_in;
      b_ff <= b_in;
      rnum_ff <= rnum_in;
      rden_ff <= rden_in;
      err_ff <= err_in;
      lout_ff <= lout_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_res_num = rnum_ff;
   assign rsp_res_den = rden_ff;
   assign rsp_zero_den_error = err_ff;
   assign rsp_last_out = lout_ff;
endmodule

// ===== rtl/rar_checker.sv =====
// rar_checker: port-level checks of rational_arith_reduce, bound to the top level
// no package dependency
module rar_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [31:0] rsp_res_den,
   input logic        rsp_zero_den_error
);
   // a taken request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("request taken but block not busy");

   // one result per request: never two strobes in a row
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   // a result comes only at the end of a busy period
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> $past(busy))
      else $error("result without a request in flight");

   // error flag and zero denominator go together
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_zero_den_error == (rsp_res_den == 32'd0)))
      else $error("error flag disagrees with denominator");
endmodule

bind rational_arith_reduce rar_checker u_rar_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_res_den        (rsp_res_den),
   .rsp_zero_den_error (rsp_zero_den_error)
);
